// File: design/lzss_window_decompressor_core_macros.svh
// ----------------------------------------------------------------------------
// LZSS window decompressor assertion macros
// Shared concurrent check forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH
`define LZSS_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication check
`define LZWD_CHECK(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication check
`define LZWD_CHECK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Types and constants shared by the LZSS window decompressor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

	// Window geometry
	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int MAX_LEN         = 18;   // start pointer sits this far below the top
	localparam int MATCH_MIN       = 3;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int OFF_W  = 12;
	localparam int LEN_W  = 5;
	localparam int SIZE_W = 32;

	localparam logic [BYTE_W-1:0] SPACE = 8'h20;

	// Input item
	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              chunk_start;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_byte;
		logic [SIZE_W-1:0] total_size;
	} out_item_t;

	// Parser to copy engine command
	typedef struct packed {
		logic              restart;    // new chunk: reset window pointer and fill
		logic              load_size;  // header complete
		logic              lit;        // emit a literal
		logic              match;      // start a window copy
		logic [BYTE_W-1:0] data;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic [SIZE_W-1:0] size;
	} cmd_t;

endpackage

`default_nettype wire

// File: design/lzwd_window_ram.sv
// ----------------------------------------------------------------------------
// lzwd_window_ram
// History window: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_window_ram #(
	parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(WINDOW_SIZE)-1:0] raddr,
	output logic      [lzwd_pkg::BYTE_W-1:0]    rdata,
	input  wire logic                          we,
	input  wire logic [$clog2(WINDOW_SIZE)-1:0] waddr,
	input  wire logic [lzwd_pkg::BYTE_W-1:0]    wdata
);

	logic [lzwd_pkg::BYTE_W-1:0] mem [WINDOW_SIZE];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/lzwd_parser.sv
// ----------------------------------------------------------------------------
// lzwd_parser
// Chunk header and flag byte parser; issues literal and match commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire lzwd_pkg::in_item_t item,
	input  wire logic               done,
	output lzwd_pkg::cmd_t          cmd,
	output logic [lzwd_pkg::SIZE_W-1:0] size
);

	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_FLAG     = 3'd1;
	localparam logic [2:0] PH_LITERAL  = 3'd3;
	localparam logic [2:0] PH_MATCH_LO = 3'd4;
	localparam logic [2:0] PH_MATCH_HI = 3'd5;

	logic [2:0]                  phase_q, phase_d, phase_base;
	logic [1:0]                  cnt_q, cnt_d, cnt_base;
	logic [lzwd_pkg::SIZE_W-1:0] cs_q, cs_d, cs_base;
	logic [8:0]                  fs_q, fs_d;
	logic [7:0]                  offlo_q, offlo_d;
	logic [7:0]                  b;

	// Phase for the next item from the remaining flag bits
	function automatic logic [2:0] choose(input logic [8:0] fs);
		if (fs <= 9'd1) begin
			return PH_FLAG;
		end else if (fs[0]) begin
			return PH_LITERAL;
		end else begin
			return PH_MATCH_LO;
		end
	endfunction

	assign b          = item.in_byte;
	assign phase_base = item.chunk_start ? PH_HEADER : phase_q;
	assign cnt_base   = item.chunk_start ? 2'd0 : cnt_q;
	assign cs_base    = item.chunk_start ? '0 : cs_q;
	assign size       = cs_q;

	// Next state and command decode
	always_comb begin
		phase_d = phase_base;
		cnt_d   = cnt_base;
		cs_d    = cs_base;
		fs_d    = fs_q;
		offlo_d = offlo_q;
		cmd     = '0;
		cmd.restart = item.chunk_start;
		cmd.data    = b;
		cmd.off     = {b[7:4], offlo_q};
		cmd.len     = lzwd_pkg::LEN_W'(b[3:0]) + lzwd_pkg::LEN_W'(lzwd_pkg::MATCH_MIN);
		if (phase_base == PH_HEADER) begin
			// little-endian size bytes
			case (cnt_base)
				2'd0:    cs_d[7:0]   = cs_base[7:0]   | b;
				2'd1:    cs_d[15:8]  = cs_base[15:8]  | b;
				2'd2:    cs_d[23:16] = cs_base[23:16] | b;
				default: cs_d[31:24] = cs_base[31:24] | b;
			endcase
			cnt_d = cnt_base + 2'd1;
			if (cnt_base == 2'd3) begin
				cmd.load_size = 1'b1;
				fs_d          = '0;
				phase_d       = PH_FLAG;
			end
		end else if (!done) begin
			unique case (phase_base)
				PH_FLAG: begin
					fs_d    = {1'b1, b};
					phase_d = choose({1'b1, b});
				end
				PH_LITERAL: begin
					cmd.lit = 1'b1;
					fs_d    = fs_q >> 1;
					phase_d = choose(fs_q >> 1);
				end
				PH_MATCH_LO: begin
					offlo_d = b;
					phase_d = PH_MATCH_HI;
				end
				PH_MATCH_HI: begin
					cmd.match = 1'b1;
					fs_d      = fs_q >> 1;
					phase_d   = choose(fs_q >> 1);
				end
				default: begin
					phase_d = PH_FLAG;
				end
			endcase
		end
		cmd.size = cs_d;
		if (!accept) begin
			cmd = '0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			cs_q    <= '0;
			fs_q    <= '0;
			offlo_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			cs_q    <= cs_d;
			fs_q    <= fs_d;
			offlo_q <= offlo_d;
		end
	end

endmodule

`default_nettype wire

// File: design/lzss_window_decompressor_core.sv
// ----------------------------------------------------------------------------
// lzss_window_decompressor_core
// LZSS decoder with a 4096-byte history window held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Compressed bytes enter one item per accept; decompressed bytes leave one
// item per cycle at best. Header, flag and first match bytes give nothing;
// a literal gives one byte; a match of length L streams up to L bytes after
// its second byte, one window read per cycle while the read stage is free,
// so the single RAM read port sets the throughput. A copy read of the entry
// that is being written in the same cycle is forwarded. The window is not
// swept at a chunk start: a fill count marks which entries the current chunk
// has written and all others read as spaces, so a new chunk can start at once.
`default_nettype none

`include "lzss_window_decompressor_core_macros.svh"

module lzss_window_decompressor_core #(
	parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lzwd_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output lzwd_pkg::out_item_t      out_item
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW-1:0] PTR_START = AW'(WINDOW_SIZE - lzwd_pkg::MAX_LEN);
	localparam logic [AW:0]   FILL_MAX  = (AW+1)'(WINDOW_SIZE);

	typedef logic [lzwd_pkg::BYTE_W-1:0] byte_t;

	lzwd_pkg::cmd_t              cmd;
	logic [lzwd_pkg::SIZE_W-1:0] chunk_size;
	logic                        accept;

	// copy engine
	logic                        copy_active_q;
	logic [AW-1:0]               cp_addr_q;
	logic [lzwd_pkg::LEN_W-1:0]  cp_left_q;
	logic [lzwd_pkg::SIZE_W-1:0] remain_q;
	logic [AW-1:0]               wp_q;
	logic [AW:0]                 fill_q;

	// read stage
	logic  valid_s1, direct_s1, hit_s1, last_s1;
	byte_t data_s1;

	logic                  out_valid_q;
	lzwd_pkg::out_item_t   out_q;

	byte_t   ram_rdata, emit_byte;
	logic    advance, s1_free, issue, wr_en, fwd, hit, last_iss;
	logic [AW-1:0] rel_addr;

	// Handshake and stage flow
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_free  = !valid_s1 || advance;
	assign in_stall = copy_active_q || !s1_free;
	assign accept   = in_valid && !in_stall;
	assign issue    = copy_active_q && s1_free;

	// Byte leaving the read stage; written back unless it ends the chunk
	assign emit_byte = direct_s1 ? data_s1 : (hit_s1 ? ram_rdata : lzwd_pkg::SPACE);
	assign wr_en     = advance && !last_s1;

	// Read address hit: forwarded write or entry filled this chunk
	assign fwd      = wr_en && (cp_addr_q == wp_q);
	assign rel_addr = cp_addr_q - PTR_START;
	assign hit      = fill_q[AW] || ({1'b0, rel_addr} < fill_q);
	assign last_iss = (remain_q == lzwd_pkg::SIZE_W'(1));

	lzwd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.done   (remain_q == '0),
		.cmd    (cmd),
		.size   (chunk_size)
	);

	lzwd_window_ram #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_ram (
		.clk   (clk),
		.rd_en (issue),
		.raddr (cp_addr_q),
		.rdata (ram_rdata),
		.we    (wr_en),
		.waddr (wp_q),
		.wdata (emit_byte)
	);

	// Copy sequencer and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_active_q <= 1'b0;
			cp_addr_q     <= '0;
			cp_left_q     <= '0;
			remain_q      <= '0;
		end else begin
			if (cmd.load_size) begin
				remain_q <= cmd.size;
			end else if (issue || cmd.lit) begin
				remain_q <= remain_q - lzwd_pkg::SIZE_W'(1);
			end
			if (cmd.match) begin
				copy_active_q <= 1'b1;
				cp_addr_q     <= AW'(cmd.off);
				cp_left_q     <= cmd.len;
			end else if (issue) begin
				cp_addr_q <= cp_addr_q + AW'(1);
				cp_left_q <= cp_left_q - lzwd_pkg::LEN_W'(1);
				if (cp_left_q == lzwd_pkg::LEN_W'(1) || last_iss) begin
					copy_active_q <= 1'b0;
				end
			end
		end
	end

	// Write pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= PTR_START;
			fill_q <= '0;
		end else if (cmd.restart) begin
			wp_q   <= PTR_START;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= wp_q + AW'(1);
			if (!fill_q[AW]) begin
				fill_q <= fill_q + (AW+1)'(1);
			end
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue || cmd.lit) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload; data only matters for a literal or a forwarded byte
	always_ff @(posedge clk) begin
		if (issue) begin
			direct_s1 <= fwd;
			data_s1   <= fwd ? emit_byte : lzwd_pkg::SPACE;
			hit_s1    <= hit;
			last_s1   <= last_iss;
		end else if (cmd.lit) begin
			direct_s1 <= 1'b1;
			data_s1   <= cmd.data;
			hit_s1    <= 1'b0;
			last_s1   <= last_iss;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_byte   <= emit_byte;
			out_q.last_byte  <= last_s1;
			out_q.total_size <= chunk_size;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Checks
	`LZWD_CHECK(a_copy_blocks_input, copy_active_q, in_stall, "input taken during copy")
	`LZWD_CHECK(a_last_ends_copy, valid_s1 && last_s1, !copy_active_q, "copy past chunk end")
	`LZWD_CHECK_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(data_s1), "stage lost")
	`LZWD_CHECK(a_fill_bound, valid_s1 || !valid_s1, fill_q <= FILL_MAX, "fill count overrun")

endmodule

`default_nettype wire

// File: tb/lzss_window_decompressor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decompressor_core_tb
// Self-checking bench for the LZSS window decompressor core.
// ----------------------------------------------------------------------------
// Compressed chunks go in through a queue-fed driver. A bit-exact software
// decoder with its own history window runs on every accepted input item
// and queues the decompressed bytes it expects. A monitor compares each
// accepted output item against the oldest expected byte. Both sides idle
// at random. Directed chunks come first, then random well-formed chunks
// mixed with truncated chunks and noise.
`default_nettype none

module lzss_window_decompressor_core_tb;

	localparam int          RANDOM_ITEMS = 236;
	localparam int          TAIL_CYCLES  = 64;
	localparam int          TAIL_CALM    = 40;    // last items run with no idling
	localparam logic [11:0] PTR_START    =
		12'(lzwd_pkg::WINDOW_SIZE_DEF - lzwd_pkg::MAX_LEN);
	localparam longint      LIMIT_NS     = 5_000_000;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_FLAG,
		PH_LITERAL,
		PH_MATCH_LO,
		PH_MATCH_HI,
		PH_DONE
	} decode_phase_t;

	// One queued compressed byte; hold marks a wait for all output to drain
	typedef struct {
		lzwd_pkg::in_item_t item;
		bit                 hold;
	} comp_byte_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	lzwd_pkg::in_item_t  in_item   = '0;
	logic                out_stall = 1'b0;
	logic                in_stall;
	logic                out_valid;
	lzwd_pkg::out_item_t out_item;

	// Stimulus and scoreboard
	comp_byte_t          compressed_q[$];
	lzwd_pkg::out_item_t decoded_q[$];
	comp_byte_t          next_byte;
	lzwd_pkg::out_item_t want;
	int         total_items   = 0;
	int         random_items  = 0;
	int         items_taken   = 0;
	int         bytes_checked = 0;
	int         last_seen     = 0;
	int         chunk_starts  = 0;
	int         mismatches    = 0;
	int         gap_left      = 0;
	int         stall_left    = 0;
	int         spell_cnt     = 0;
	bit         calm_spell    = 1'b0;
	logic       idle_ok;

	// Software decoder state
	logic [7:0]    hist_win [lzwd_pkg::WINDOW_SIZE_DEF];
	logic [11:0]   wr_ptr;
	logic [8:0]    flag_bits;
	logic [31:0]   left_cnt;
	logic [2:0]    hdr_cnt;
	decode_phase_t phase;
	logic [7:0]    off_lo;
	logic [31:0]   size_hdr;

	lzss_window_decompressor_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #4 clk = ~clk;

	assign idle_ok = !calm_spell && (items_taken + TAIL_CALM < total_items);

	// ------------------------------------------------------------------
	// Software decoder
	// ------------------------------------------------------------------
	function automatic void restart_window();
		for (int i = 0; i < lzwd_pkg::WINDOW_SIZE_DEF; i++)
			hist_win[i] = lzwd_pkg::SPACE;
		wr_ptr    = PTR_START;
		flag_bits = '0;
		left_cnt  = '0;
		hdr_cnt   = '0;
		phase     = PH_HEADER;
		off_lo    = '0;
		size_hdr  = '0;
	endfunction

	// Next phase from the current flag bit; a lone marker means a new flag byte
	function automatic void pick_phase();
		if (flag_bits <= 9'd1)
			phase = PH_FLAG;
		else if (flag_bits[0])
			phase = PH_LITERAL;
		else
			phase = PH_MATCH_LO;
	endfunction

	// Queue one decoded byte; returns 1 once the chunk is complete
	function automatic bit put_byte(input logic [7:0] v);
		lzwd_pkg::out_item_t r;
		left_cnt     = left_cnt - 32'd1;
		r.out_byte   = v;
		r.last_byte  = (left_cnt == 32'd0);
		r.total_size = size_hdr;
		decoded_q.insert(decoded_q.size(), r);
		if (left_cnt == 32'd0) begin
			phase = PH_DONE;
			return 1'b1;
		end
		hist_win[wr_ptr] = v;
		wr_ptr = wr_ptr + 12'd1;
		return 1'b0;
	endfunction

	function automatic void decode_byte(input lzwd_pkg::in_item_t it);
		logic [11:0] off;
		int          len;
		bit          done;
		if (it.chunk_start)
			restart_window();
		case (phase)
			PH_HEADER: begin
				size_hdr = size_hdr | (32'(it.in_byte) << (8 * hdr_cnt[1:0]));
				hdr_cnt  = hdr_cnt + 3'd1;
				if (hdr_cnt >= 3'd4) begin
					left_cnt  = size_hdr;
					flag_bits = '0;
					phase     = (size_hdr == 32'd0) ? PH_DONE : PH_FLAG;
				end
			end
			PH_FLAG: begin
				flag_bits = {1'b1, it.in_byte};
				pick_phase();
			end
			PH_LITERAL: begin
				if (!put_byte(it.in_byte)) begin
					flag_bits = flag_bits >> 1;
					pick_phase();
				end
			end
			PH_MATCH_LO: begin
				off_lo = it.in_byte;
				phase  = PH_MATCH_HI;
			end
			PH_MATCH_HI: begin
				off  = {it.in_byte[7:4], off_lo};
				len  = int'(it.in_byte[3:0]) + lzwd_pkg::MATCH_MIN;
				done = 1'b0;
				for (int i = 0; i < len && !done; i++)
					done = put_byte(hist_win[off + 12'(i)]);
				if (!done) begin
					flag_bits = flag_bits >> 1;
					pick_phase();
				end
			end
			default: phase = PH_DONE;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b, input logic cs = 1'b0,
			input bit hold = 1'b0);
		comp_byte_t s;
		s.item.in_byte     = b;
		s.item.chunk_start = cs;
		s.hold             = hold;
		compressed_q.insert(compressed_q.size(), s);
	endtask

	// Size header, little-endian, first byte starts the chunk
	task automatic add_header(input logic [31:0] size, input bit hold);
		add_byte(size[7:0], 1'b1, hold);
		add_byte(size[15:8]);
		add_byte(size[23:16]);
		add_byte(size[31:24]);
	endtask

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 19))
			0:          return 0;
			1:          return $urandom_range(200, 400);
			2, 3, 4, 5: return $urandom_range(41, 120);
			default:    return $urandom_range(1, 40);
		endcase
	endfunction

	// Well-formed chunk with random content; a small budget truncates it
	task automatic queue_chunk(input int unsigned size, input int budget, input bit hold);
		int unsigned made;
		logic [11:0] wp;
		logic [11:0] off;
		logic [7:0]  fl;
		int          len;
		add_header(size, hold);
		random_items += 4;
		made = 0;
		wp   = PTR_START;
		while (made < size && budget > 0) begin
			case ($urandom_range(0, 9))
				0:       fl = 8'h00;
				1:       fl = 8'hFF;
				default: fl = 8'($urandom);
			endcase
			add_byte(fl);
			random_items++;
			budget--;
			for (int k = 0; k < 8 && made < size && budget > 0; k++) begin
				if (fl[k]) begin
					add_byte(8'($urandom));
					made++;
					wp++;
					random_items++;
					budget--;
				end else begin
					// mostly recent history, sometimes anywhere in the window
					if ($urandom_range(0, 2) != 0)
						off = wp - 12'($urandom_range(1, 31));
					else
						off = 12'($urandom);
					len = $urandom_range(0, 15);
					add_byte(off[7:0]);
					add_byte({off[11:8], 4'(len)});
					random_items += 2;
					budget -= 2;
					len += lzwd_pkg::MATCH_MIN;
					if (len > int'(size - made))
						len = int'(size - made);
					made += len;
					wp   += 12'(len);
				end
			end
		end
		// bytes past the end of a finished chunk are ignored
		if (made >= size)
			repeat ($urandom_range(0, 2))
				add_byte(8'($urandom));
	endtask

	// Random bytes with a rare restart anywhere
	task automatic queue_noise();
		int n;
		n = $urandom_range(3, 14);
		add_byte(8'($urandom), 1'b1);
		for (int i = 1; i < n; i++)
			add_byte(8'($urandom), 1'($urandom_range(0, 15) == 0));
		random_items += n;
	endtask

	// ------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (compressed_q.size() == 0 ||
					(compressed_q[0].hold && (in_valid || decoded_q.size() != 0))) begin
				in_valid <= 1'b0;
			end else if (idle_ok && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				gap_left <= $urandom_range(0, 13);
			end else begin
				next_byte = compressed_q.pop_front();
				in_item  <= next_byte.item;
				in_valid <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stall bursts
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_ok && $urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Alternate spells with and without idling
	always @(posedge clk) begin
		spell_cnt <= spell_cnt + 1;
		if (spell_cnt % 128 == 0)
			calm_spell <= ($urandom_range(0, 3) == 0);
	end

	// ------------------------------------------------------------------
	// Monitor: predict on input accept, then check output accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(in_item);
				items_taken++;
				if (in_item.chunk_start)
					chunk_starts++;
			end
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected item, got byte %02h last %b size %08h",
						$time, out_item.out_byte, out_item.last_byte, out_item.total_size);
				end else begin
					want = decoded_q.pop_front();
					bytes_checked++;
					if (want.last_byte)
						last_seen++;
					if (out_item.out_byte !== want.out_byte) begin
						mismatches++;
						$display("%0t ns: out_byte expected %02h, got %02h",
							$time, want.out_byte, out_item.out_byte);
					end
					if (out_item.last_byte !== want.last_byte) begin
						mismatches++;
						$display("%0t ns: last_byte expected %b, got %b",
							$time, want.last_byte, out_item.last_byte);
					end
					if (out_item.total_size !== want.total_size) begin
						mismatches++;
						$display("%0t ns: total_size expected %08h, got %08h",
							$time, want.total_size, out_item.total_size);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		restart_window();

		// Bytes before any chunk start: size 20, flags match/literal/match
		add_byte(8'h14);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'h02);
		add_byte(8'hEE);             // 18 bytes from the top of the window
		add_byte(8'hFF);
		add_byte(8'hFF);             // literal
		add_byte(8'h00);             // offset 0, length 3, cut by the size
		add_byte(8'h00);
		add_byte(8'hAA);             // ignored after completion

		// Zero size, then an ignored byte
		add_header(32'h0000_0000, 1'b1);
		add_byte(8'h55);

		// Maximum size; literal then an 18-byte copy of the byte just written,
		// the chunk then cut short by the restart that follows
		add_header(32'hFFFF_FFFF, 1'b1);
		add_byte(8'h01);
		add_byte(8'h00);
		add_byte(8'hEE);
		add_byte(8'hFF);

		// Random part; the last chunks are trimmed to keep the item count near the goal
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0:       queue_noise();
				1:       queue_chunk(pick_size(), $urandom_range(3, 20), 1'b0);
				default: queue_chunk(pick_size(), RANDOM_ITEMS - random_items + 16,
						$urandom_range(0, 3) == 0);
			endcase
		end
		total_items = compressed_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < total_items)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Decoded %0d compressed items over %0d chunk starts;", items_taken,
			chunk_starts);
		$display("checked %0d output bytes, %0d of them end-of-chunk.", bytes_checked,
			last_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("Timeout with %0d of %0d items accepted, %0d bytes outstanding",
			items_taken, total_items, decoded_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
